// ===== hw/rtl/pfr_pkg.sv =====
// Shared types and constants for the page frame replacement core.
package pfr_pkg;

  localparam int FRAME_DEPTH = 64;
  localparam int PAGE_BITS   = 12;
  localparam int FRAME_W     = $clog2(FRAME_DEPTH);
  localparam int NCNT_W      = FRAME_W + 1;
  localparam int CNT_W       = 32;
  localparam int SEED_W      = 48;
  localparam int CHUNK_W     = 16;
  localparam int MUL_W       = 35;
  localparam int RAND_W      = 31;
  localparam int RAND_LSB    = 17;
  localparam int STEP_W      = $clog2(RAND_W);

  localparam logic [MUL_W-1:0]  LCG_MUL  = 35'h5DEECE66D;
  localparam logic [SEED_W-1:0] LCG_ADD  = 48'h00000000000B;
  localparam logic [SEED_W-1:0] LCG_SEED = 48'h1234ABCD330E;

  typedef enum logic [0:0] {
    REG_POLICY_MODE   = 1'b0,
    REG_FRAMES_IN_USE = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    MODE_FIFO   = 1'b0,
    MODE_RANDOM = 1'b1
  } policy_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RAND,
    S_READ,
    S_DONE
  } pfr_state_t;

  typedef enum logic [1:0] {
    R_IDLE,
    R_MUL,
    R_MOD
  } rnd_state_t;

  typedef struct packed {
    logic               done;
    logic [FRAME_W-1:0] value;
  } rnd_rsp_t;

endpackage

// ===== hw/rtl/pfr_rand_unit.sv =====
// Iterative lrand48 step (three partial products) and bit-serial modulo by frame count.
module pfr_rand_unit
  import pfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NCNT_W-1:0] n_frames,
  output rnd_rsp_t          rsp
);

  rnd_state_t            state_r, state_nxt;
  logic [SEED_W-1:0]     seed_r, seed_nxt;
  logic [SEED_W-1:0]     acc_r, acc_nxt;
  logic [RAND_W-1:0]     val_r, val_nxt;
  logic [NCNT_W-1:0]     rem_r, rem_nxt;
  logic [STEP_W-1:0]     cnt_r, cnt_nxt;
  logic                  done_r, done_nxt;
  logic [CHUNK_W-1:0]    chunk;
  logic [CHUNK_W+MUL_W-1:0] prod;
  logic [SEED_W-1:0]     prod_sh;
  logic [NCNT_W-1:0]     trial;

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    chunk = seed_r[CHUNK_W-1:0];
      2'd1:    chunk = seed_r[2*CHUNK_W-1:CHUNK_W];
      default: chunk = seed_r[3*CHUNK_W-1:2*CHUNK_W];
    endcase
    prod = {{MUL_W{1'b0}}, chunk} * {{CHUNK_W{1'b0}}, LCG_MUL};
    case (cnt_r[1:0])
      2'd0:    prod_sh = prod[SEED_W-1:0];
      2'd1:    prod_sh = {prod[SEED_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
      default: prod_sh = {prod[SEED_W-2*CHUNK_W-1:0], {2*CHUNK_W{1'b0}}};
    endcase
    trial = {rem_r[NCNT_W-2:0], val_r[RAND_W-1]};
  end

  always_comb begin
    state_nxt = state_r;
    seed_nxt  = seed_r;
    acc_nxt   = acc_r;
    val_nxt   = val_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      R_IDLE: begin
        if (start) begin
          acc_nxt   = LCG_ADD;
          cnt_nxt   = '0;
          state_nxt = R_MUL;
        end
      end
      R_MUL: begin
        acc_nxt = acc_r + prod_sh;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == STEP_W'(2)) begin
          seed_nxt  = acc_nxt;
          val_nxt   = acc_nxt[RAND_LSB+RAND_W-1:RAND_LSB];
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = R_MOD;
        end
      end
      R_MOD: begin
        rem_nxt = (trial >= n_frames) ? trial - n_frames : trial;
        val_nxt = {val_r[RAND_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == STEP_W'(RAND_W - 1)) begin
          done_nxt  = 1'b1;
          state_nxt = R_IDLE;
        end
      end
      default: state_nxt = R_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
      seed_r  <= LCG_SEED;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      seed_r  <= seed_nxt;
      done_r  <= done_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    val_r <= val_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done  = done_r;
  assign rsp.value = rem_r[FRAME_W-1:0];

endmodule

// ===== hw/rtl/pfr_frame_store.sv =====
// Frame owner store: one write port, one registered read port.
module pfr_frame_store
  import pfr_pkg::*;
(
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [FRAME_W-1:0]   wr_addr,
  input  logic [PAGE_BITS-1:0] wr_data,
  input  logic                 rd_en,
  input  logic [FRAME_W-1:0]   rd_addr,
  output logic [PAGE_BITS-1:0] rd_data
);

  logic [PAGE_BITS-1:0] mem_r [FRAME_DEPTH];
  logic [PAGE_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/page_frame_replacement_core.sv =====
// Page frame replacement core: sequencer, counters, config and result registers.
//
// Usage: pulse start with in_fault_page while busy is low; the fault is taken
// at that edge and busy stays high until the result is registered. Each fault
// gives exactly one result beat, marked by out_valid for one cycle; the
// receiver cannot stall it and must take it in that cycle.
// Path from the accepting edge to out_valid: while free frames remain, the
// done state registers the result; a round-robin eviction passes the read
// state (victim owner read) first; a random eviction waits for the random
// unit (three 16-bit partial products for the generator step, then 31 one-bit
// steps of the modulo by the frame count) before the read state. busy falls as
// out_valid rises, so the next fault can be taken at the edge ending the beat.
// Config: cfg_valid/cfg_ready write channel, cfg_index 0 = policy mode,
// 1 = frames in use; cfg_ready is always high; write only while idle.
// Reset (rst_n low, synchronous) clears counters, frame fill and pointer,
// reloads the generator seed, mode 0 and 64 frames. The owner store is not
// cleared; each frame is written before it is ever read.
module page_frame_replacement_core
  import pfr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [PAGE_BITS-1:0] in_fault_page,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  cfg_idx_t             cfg_index,
  input  logic [NCNT_W-1:0]    cfg_data,
  output logic                 out_valid,
  output logic [FRAME_W-1:0]   out_frame,
  output logic                 out_evicted,
  output logic [PAGE_BITS-1:0] out_victim_page,
  output logic [CNT_W-1:0]     out_fault_total,
  output logic [CNT_W-1:0]     out_writeback_total
);

  pfr_state_t           state_r, state_nxt;
  policy_t              mode_r;
  logic [NCNT_W-1:0]    fiu_r;
  logic [NCNT_W-1:0]    filled_r, filled_nxt;
  logic [FRAME_W-1:0]   vp_r, vp_nxt;
  logic [CNT_W-1:0]     fault_cnt_r, fault_cnt_nxt;
  logic [CNT_W-1:0]     wb_cnt_r, wb_cnt_nxt;
  logic [PAGE_BITS-1:0] page_r, page_nxt;
  logic [FRAME_W-1:0]   frame_r, frame_nxt;
  logic                 evict_r, evict_nxt;
  logic [NCNT_W-1:0]    n_r, n_nxt;
  logic [NCNT_W-1:0]    n_act;
  logic [FRAME_W-1:0]   rr_frame;
  logic [NCNT_W-1:0]    rr_inc;
  logic                 accept;
  logic                 rnd_start;
  rnd_rsp_t             rnd_rsp;
  logic [PAGE_BITS-1:0] rd_data;

  logic                 out_valid_r, out_valid_nxt;
  logic [FRAME_W-1:0]   out_frame_r, out_frame_nxt;
  logic                 out_evicted_r, out_evicted_nxt;
  logic [PAGE_BITS-1:0] out_victim_r, out_victim_nxt;
  logic [CNT_W-1:0]     out_fault_r, out_fault_nxt;
  logic [CNT_W-1:0]     out_wb_r, out_wb_nxt;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start & ~busy;
  assign cfg_ready = 1'b1;

  always_comb begin
    if (fiu_r == '0) begin
      n_act = NCNT_W'(1);
    end else if (fiu_r > NCNT_W'(FRAME_DEPTH)) begin
      n_act = NCNT_W'(FRAME_DEPTH);
    end else begin
      n_act = fiu_r;
    end
    rr_frame = (NCNT_W'(vp_r) < n_act) ? vp_r : '0;
    rr_inc   = NCNT_W'(rr_frame) + 1'b1;
  end

  always_comb begin
    state_nxt       = state_r;
    filled_nxt      = filled_r;
    vp_nxt          = vp_r;
    fault_cnt_nxt   = fault_cnt_r;
    wb_cnt_nxt      = wb_cnt_r;
    page_nxt        = page_r;
    frame_nxt       = frame_r;
    evict_nxt       = evict_r;
    n_nxt           = n_r;
    rnd_start       = 1'b0;
    out_valid_nxt   = 1'b0;
    out_frame_nxt   = out_frame_r;
    out_evicted_nxt = out_evicted_r;
    out_victim_nxt  = out_victim_r;
    out_fault_nxt   = out_fault_r;
    out_wb_nxt      = out_wb_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          page_nxt = in_fault_page;
          n_nxt    = n_act;
          if (filled_r < n_act) begin
            frame_nxt  = filled_r[FRAME_W-1:0];
            filled_nxt = filled_r + 1'b1;
            evict_nxt  = 1'b0;
            state_nxt  = S_DONE;
          end else begin
            evict_nxt = 1'b1;
            if (mode_r == MODE_FIFO) begin
              frame_nxt = rr_frame;
              vp_nxt    = (rr_inc == n_act) ? '0 : rr_inc[FRAME_W-1:0];
              state_nxt = S_READ;
            end else begin
              rnd_start = 1'b1;
              state_nxt = S_RAND;
            end
          end
        end
      end
      S_RAND: begin
        if (rnd_rsp.done) begin
          frame_nxt = rnd_rsp.value;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        fault_cnt_nxt   = fault_cnt_r + 1'b1;
        wb_cnt_nxt      = evict_r ? wb_cnt_r + 1'b1 : wb_cnt_r;
        out_valid_nxt   = 1'b1;
        out_frame_nxt   = frame_r;
        out_evicted_nxt = evict_r;
        out_victim_nxt  = evict_r ? rd_data : '0;
        out_fault_nxt   = fault_cnt_nxt;
        out_wb_nxt      = wb_cnt_nxt;
        state_nxt       = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_FIFO;
      fiu_r       <= NCNT_W'(FRAME_DEPTH);
      filled_r    <= '0;
      vp_r        <= '0;
      fault_cnt_r <= '0;
      wb_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      filled_r    <= filled_nxt;
      vp_r        <= vp_nxt;
      fault_cnt_r <= fault_cnt_nxt;
      wb_cnt_r    <= wb_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_POLICY_MODE:   mode_r <= policy_t'(cfg_data[0]);
          REG_FRAMES_IN_USE: fiu_r  <= cfg_data;
          default:           mode_r <= mode_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    page_r        <= page_nxt;
    frame_r       <= frame_nxt;
    evict_r       <= evict_nxt;
    n_r           <= n_nxt;
    out_frame_r   <= out_frame_nxt;
    out_evicted_r <= out_evicted_nxt;
    out_victim_r  <= out_victim_nxt;
    out_fault_r   <= out_fault_nxt;
    out_wb_r      <= out_wb_nxt;
  end

  pfr_rand_unit u_rand (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rnd_start),
    .n_frames (n_nxt),
    .rsp      (rnd_rsp)
  );

  pfr_frame_store u_store (
    .clk     (clk),
    .wr_en   (state_r == S_DONE),
    .wr_addr (frame_r),
    .wr_data (page_r),
    .rd_en   (state_r == S_READ),
    .rd_addr (frame_r),
    .rd_data (rd_data)
  );

  assign out_valid           = out_valid_r;
  assign out_frame           = out_frame_r;
  assign out_evicted         = out_evicted_r;
  assign out_victim_page     = out_victim_r;
  assign out_fault_total     = out_fault_r;
  assign out_writeback_total = out_wb_r;

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_DONE))
    else $error("result beat without a finished fault");

  a_frame_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (NCNT_W'(out_frame) < n_r))
    else $error("frame beyond active frame count");

  a_rand_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    rnd_rsp.done |-> (state_r == S_RAND))
    else $error("random unit finished outside wait state");

  a_fault_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_fault_total == fault_cnt_r))
    else $error("fault total out of step with counter");

endmodule
